// ----- rtl/pfre_pkg.sv -----
`default_nettype none

package pfre_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ROW_W         = PAGE_W + 3;
  localparam int ADDR_W        = $clog2(STORE_BYTES);

  typedef enum logic [2:0] {
    OP_FILL_SCREEN = 3'd0,
    OP_FILL_RECT   = 3'd1,
    OP_OUTLINE     = 3'd2,
    OP_INVERT      = 3'd3,
    OP_READ        = 3'd4
  } pfre_op_e;

  typedef enum logic [1:0] {
    MODE_CLEAR,
    MODE_SET,
    MODE_FLIP
  } pfre_mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_FILL,
    ST_WALK,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } pfre_state_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic               white;
    logic [6:0]         read_column;
    logic [2:0]         read_page;
  } pfre_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       touched;
  } pfre_out_t;

  typedef struct packed {
    logic             hit;
    logic             outline;
    pfre_mode_e       mode;
    logic             top;
    logic             bottom;
    logic             left;
    logic             right;
    logic [COL_W-1:0] xs;
    logic [COL_W-1:0] xl;
    logic [ROW_W-1:0] ys;
    logic [ROW_W-1:0] yl;
  } pfre_clip_t;

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [PAGE_W-1:0] page,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(page) * ADDR_W'(SCREEN_WIDTH);
    return base + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pfre_ram.sv -----
`default_nettype none

module pfre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/pfre_clip.sv -----
`default_nettype none

module pfre_clip
  import pfre_pkg::*;
(
  input  wire pfre_in_t cmd_i,
  output pfre_clip_t    clip_o
);

  localparam logic signed [16:0] WIDTH_S  = 17'(SCREEN_WIDTH);
  localparam logic signed [16:0] HEIGHT_S = 17'(SCREEN_HEIGHT);

  logic signed [16:0] x_s, y_s, w_s, h_s;
  logic signed [16:0] xe, ye, xl_full, yl_full;

  always_comb begin
    x_s     = {cmd_i.x_pos[15], cmd_i.x_pos};
    y_s     = {cmd_i.y_pos[15], cmd_i.y_pos};
    w_s     = {cmd_i.rect_width[15], cmd_i.rect_width};
    h_s     = {cmd_i.rect_height[15], cmd_i.rect_height};
    xe      = x_s + w_s;
    ye      = y_s + h_s;
    xl_full = xe - 17'sd1;
    yl_full = ye - 17'sd1;

    clip_o.hit     = (w_s > 17'sd0) && (h_s > 17'sd0) && (x_s < WIDTH_S) &&
                     (y_s < HEIGHT_S) && (xe > 17'sd0) && (ye > 17'sd0);
    clip_o.outline = (cmd_i.operation == OP_OUTLINE);
    if (cmd_i.operation == OP_INVERT) begin
      clip_o.mode = MODE_FLIP;
    end else if (cmd_i.white) begin
      clip_o.mode = MODE_SET;
    end else begin
      clip_o.mode = MODE_CLEAR;
    end
    clip_o.left   = ~cmd_i.x_pos[15];
    clip_o.top    = ~cmd_i.y_pos[15];
    clip_o.right  = (xl_full < WIDTH_S);
    clip_o.bottom = (yl_full < HEIGHT_S);
    clip_o.xs     = (x_s > 17'sd0) ? COL_W'(x_s) : '0;
    clip_o.ys     = (y_s > 17'sd0) ? ROW_W'(y_s) : '0;
    clip_o.xl     = clip_o.right ? COL_W'(xl_full) : COL_W'(SCREEN_WIDTH - 1);
    clip_o.yl     = clip_o.bottom ? ROW_W'(yl_full) : ROW_W'(SCREEN_HEIGHT - 1);
  end

endmodule

`default_nettype wire

// ----- rtl/pfre_mask.sv -----
`default_nettype none

module pfre_mask
  import pfre_pkg::*;
(
  input  wire pfre_clip_t        clip_i,
  input  wire logic [COL_W-1:0]  col_i,
  input  wire logic [PAGE_W-1:0] page_i,
  output logic [7:0]             mask_o
);

  logic       first_page, last_page;
  logic [2:0] lo, hi;
  logic [7:0] span, lo_mask, hi_mask, edge_mask;

  always_comb begin
    first_page = (page_i == clip_i.ys[ROW_W-1:3]);
    last_page  = (page_i == clip_i.yl[ROW_W-1:3]);
    lo         = first_page ? clip_i.ys[2:0] : 3'd0;
    hi         = last_page ? clip_i.yl[2:0] : 3'd7;
    lo_mask    = 8'hFF << lo;
    hi_mask    = 8'hFF >> (3'd7 - hi);
    span       = lo_mask & hi_mask;

    edge_mask = 8'h00;
    if (clip_i.top && first_page) begin
      edge_mask = edge_mask | (8'h01 << clip_i.ys[2:0]);
    end
    if (clip_i.bottom && last_page) begin
      edge_mask = edge_mask | (8'h01 << clip_i.yl[2:0]);
    end
    if (clip_i.left && (col_i == clip_i.xs)) begin
      edge_mask = edge_mask | span;
    end
    if (clip_i.right && (col_i == clip_i.xl)) begin
      edge_mask = edge_mask | span;
    end

    mask_o = clip_i.outline ? edge_mask : span;
  end

endmodule

`default_nettype wire

// ----- rtl/page_framebuffer_rect_engine_core.sv -----
`default_nettype none

// Monochrome page framebuffer with a rectangle engine.
// Input channel in_valid_i / in_stall_o carries one command beat (pfre_in_t);
// output channel out_valid_o / out_stall_i returns exactly one result beat
// (pfre_out_t) per command. A beat moves when valid is high and stall is low.
// The store holds SCREEN_WIDTH x PAGE_COUNT bytes in one single-port-write,
// registered-read RAM; all work goes byte by byte through its ports.
// Work per command, from acceptance to result ready:
//   fill screen     : every byte of the store written, one byte a cycle
//   rectangle ops   : the columns of each page of the clipped area, page by page
//                     (read-modify-write, one byte a cycle, then a drain step)
//   read byte       : one registered RAM read; empty, off-screen or unknown commands go from setup straight to done
// One command is in flight at a time; in_stall_o is high until its result is
// placed in the output register. A new command may be taken while that result
// still waits; if the receiver stalls, the next result waits in the engine.
// After reset the store is cleared by a pass over all STORE_BYTES bytes (1024);
// in_stall_o stays high throughout it.
module page_framebuffer_rect_engine_core
  import pfre_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire pfre_in_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output pfre_out_t     out_data_o
);

  pfre_state_e       state_q, state_d;
  pfre_in_t          cmd_q;
  pfre_clip_t        clip_d, clip_q;
  pfre_out_t         res_q, out_q;
  logic              out_valid_q;
  logic [COL_W-1:0]  col_q;
  logic [PAGE_W-1:0] page_q;
  logic              pend_q;
  logic [ADDR_W-1:0] pend_addr_q;
  logic [7:0]        pend_mask_q;
  logic [7:0]        mask;
  logic [7:0]        rdata, wdata, rmw_data;
  logic [ADDR_W-1:0] raddr, waddr;
  logic              we;
  logic              sweep_last, walk_last_col, walk_last;
  logic              read_ok, load_out;

  pfre_clip u_clip (
    .cmd_i  (cmd_q),
    .clip_o (clip_d)
  );

  pfre_mask u_mask (
    .clip_i (clip_q),
    .col_i  (col_q),
    .page_i (page_q),
    .mask_o (mask)
  );

  pfre_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    sweep_last    = (col_q == COL_W'(SCREEN_WIDTH - 1)) &&
                    (page_q == PAGE_W'(PAGE_COUNT - 1));
    walk_last_col = (col_q == clip_q.xl);
    walk_last     = walk_last_col && (page_q == clip_q.yl[ROW_W-1:3]);
    read_ok       = (32'(cmd_q.read_column) < SCREEN_WIDTH) &&
                    (32'(cmd_q.read_page) < PAGE_COUNT);
    load_out      = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

    case (clip_q.mode)
      MODE_SET:   rmw_data = rdata | pend_mask_q;
      MODE_CLEAR: rmw_data = rdata & ~pend_mask_q;
      default:    rmw_data = rdata ^ pend_mask_q;
    endcase

    we    = pend_q || (state_q == ST_FILL) || (state_q == ST_CLEAR);
    waddr = pend_q ? pend_addr_q : byte_addr(page_q, col_q);
    if (pend_q) begin
      wdata = rmw_data;
    end else if ((state_q == ST_FILL) && cmd_q.white) begin
      wdata = 8'hFF;
    end else begin
      wdata = 8'h00;
    end

    if (state_q == ST_SETUP) begin
      raddr = byte_addr(PAGE_W'(cmd_q.read_page), COL_W'(cmd_q.read_column));
    end else begin
      raddr = byte_addr(page_q, col_q);
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_CLEAR: begin
        if (sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        case (cmd_q.operation)
          OP_FILL_SCREEN: state_d = ST_FILL;
          OP_READ:        state_d = read_ok ? ST_READ : ST_DONE;
          OP_FILL_RECT,
          OP_OUTLINE,
          OP_INVERT:      state_d = clip_d.hit ? ST_WALK : ST_DONE;
          default:        state_d = ST_DONE;
        endcase
      end
      ST_FILL: begin
        if (sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_READ:  state_d = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      col_q       <= '0;
      page_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == ST_WALK);

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR, ST_FILL: begin
          if (col_q == COL_W'(SCREEN_WIDTH - 1)) begin
            col_q  <= '0;
            page_q <= sweep_last ? '0 : page_q + PAGE_W'(1);
          end else begin
            col_q <= col_q + COL_W'(1);
          end
        end
        ST_SETUP: begin
          if (cmd_q.operation == OP_FILL_SCREEN) begin
            col_q  <= '0;
            page_q <= '0;
          end else begin
            col_q  <= clip_d.xs;
            page_q <= clip_d.ys[ROW_W-1:3];
          end
        end
        ST_WALK: begin
          if (walk_last_col) begin
            col_q  <= clip_q.xs;
            page_q <= page_q + PAGE_W'(1);
          end else begin
            col_q <= col_q + COL_W'(1);
          end
        end
        default: begin
          col_q  <= col_q;
          page_q <= page_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      cmd_q <= in_data_i;
    end
    if (state_q == ST_SETUP) begin
      clip_q          <= clip_d;
      res_q.read_data <= 8'h00;
      case (cmd_q.operation)
        OP_FILL_SCREEN: res_q.touched <= 1'b1;
        OP_FILL_RECT,
        OP_OUTLINE,
        OP_INVERT:      res_q.touched <= clip_d.hit;
        default:        res_q.touched <= 1'b0;
      endcase
    end
    if (state_q == ST_READ) begin
      res_q.read_data <= rdata;
    end
    if (state_q == ST_WALK) begin
      pend_addr_q <= byte_addr(page_q, col_q);
      pend_mask_q <= mask;
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
  import pfre_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam int RANDOM_COMMANDS = 580;

  class frame_scoreboard;
    logic [7:0] pixels[STORE_BYTES];
    pfre_out_t  awaited_results[$];
    int mismatches;
    int checked;
    int rect_cmds;
    int read_cmds;
    int screen_fills;
    int spare_cmds;

    function new();
      foreach (pixels[i]) pixels[i] = 8'h00;
    endfunction

    function void paint(int x0, int x1, int y0, int y1, pfre_mode_e mode);
      int idx;
      logic [7:0] mask;
      for (int y = y0; y <= y1; y++) begin
        for (int x = x0; x <= x1; x++) begin
          idx  = (y >>> 3) * SCREEN_WIDTH + x;
          mask = 8'h01 << (y & 7);
          if (idx < STORE_BYTES) begin
            case (mode)
              MODE_SET:   pixels[idx] = pixels[idx] | mask;
              MODE_CLEAR: pixels[idx] = pixels[idx] & ~mask;
              default:    pixels[idx] = pixels[idx] ^ mask;
            endcase
          end
        end
      end
    endfunction

    function pfre_out_t render_command(pfre_in_t cmd);
      pfre_out_t  res;
      pfre_mode_e mode;
      int x, y, w, h, xs, ys, xl, yl;
      bit left, top, right, bottom;
      res = '0;
      x = int'(cmd.x_pos);
      y = int'(cmd.y_pos);
      w = int'(cmd.rect_width);
      h = int'(cmd.rect_height);
      case (cmd.operation)
        OP_FILL_SCREEN: begin
          screen_fills++;
          foreach (pixels[i]) pixels[i] = {8{cmd.white}};
          res.touched = 1'b1;
        end
        OP_READ: begin
          read_cmds++;
          if (cmd.read_column < SCREEN_WIDTH && cmd.read_page < PAGE_COUNT)
            res.read_data = pixels[int'(cmd.read_page) * SCREEN_WIDTH + int'(cmd.read_column)];
        end
        OP_FILL_RECT, OP_OUTLINE, OP_INVERT: begin
          rect_cmds++;
          if (w >= 1 && h >= 1 && x < SCREEN_WIDTH && y < SCREEN_HEIGHT &&
              x + w > 0 && y + h > 0) begin
            res.touched = 1'b1;
            xs = (x > 0) ? x : 0;
            ys = (y > 0) ? y : 0;
            xl = x + w - 1;
            yl = y + h - 1;
            mode = cmd.white ? MODE_SET : MODE_CLEAR;
            if (cmd.operation == OP_OUTLINE) begin
              left   = x >= 0;
              top    = y >= 0;
              right  = xl < SCREEN_WIDTH;
              bottom = yl < SCREEN_HEIGHT;
              if (!right) xl = SCREEN_WIDTH - 1;
              if (!bottom) yl = SCREEN_HEIGHT - 1;
              if (top) paint(xs, xl, ys, ys, mode);
              if (bottom) paint(xs, xl, yl, yl, mode);
              if (left) paint(xs, xs, ys, yl, mode);
              if (right) paint(xl, xl, ys, yl, mode);
            end else begin
              if (cmd.operation == OP_INVERT) mode = MODE_FLIP;
              if (xl > SCREEN_WIDTH - 1) xl = SCREEN_WIDTH - 1;
              if (yl > SCREEN_HEIGHT - 1) yl = SCREEN_HEIGHT - 1;
              paint(xs, xl, ys, yl, mode);
            end
          end
        end
        default: spare_cmds++;
      endcase
      return res;
    endfunction

    function void note_command(pfre_in_t cmd);
      awaited_results.push_back(render_command(cmd));
    endfunction

    function void check_result(pfre_out_t got);
      pfre_out_t want;
      if (awaited_results.size() == 0) begin
        $error("result beat with no command pending: read_data %0h touched %0b",
               got.read_data, got.touched);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
        mismatches++;
      end
      if (got.touched !== want.touched) begin
        $error("touched: expected %0b, got %0b", want.touched, got.touched);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  pfre_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pfre_out_t out_data;

  frame_scoreboard board = new();

  int burst_left = 0;
  int calm_left = 0;
  int hold_left = 0;

  always #6 clk = ~clk;

  page_framebuffer_rect_engine_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // check the beat, then pick the next stall level
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 5))
        0: calm_left = $urandom_range(20, 200);
        1: hold_left = $urandom_range(1, 20);
        default: out_stall <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  function automatic pfre_in_t make_cmd(logic [2:0] op, int x, int y, int w, int h,
                                        logic white, int col, int page);
    pfre_in_t cmd;
    cmd.operation   = op;
    cmd.x_pos       = 16'(x);
    cmd.y_pos       = 16'(y);
    cmd.rect_width  = 16'(w);
    cmd.rect_height = 16'(h);
    cmd.white       = white;
    cmd.read_column = 7'(col);
    cmd.read_page   = 3'(page);
    return cmd;
  endfunction

  function automatic pfre_in_t random_cmd();
    logic [95:0] raw;
    pfre_in_t    cmd;
    int          pick;
    pick = $urandom_range(0, 99);
    raw  = {$urandom, $urandom, $urandom};
    cmd  = raw[$bits(pfre_in_t)-1:0];
    if (pick < 8) return cmd;
    if (pick < 38) begin
      cmd.operation = OP_READ;
    end else if (pick < 41) begin
      cmd.operation = OP_FILL_SCREEN;
    end else if (pick < 44) begin
      cmd.operation = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end else begin
      case ($urandom_range(0, 2))
        0: cmd.operation = OP_FILL_RECT;
        1: cmd.operation = OP_OUTLINE;
        default: cmd.operation = OP_INVERT;
      endcase
      cmd.x_pos = 16'(int'($urandom_range(0, 143)) - 8);
      cmd.y_pos = 16'(int'($urandom_range(0, 79)) - 8);
      cmd.rect_width  = 16'(($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 200)) - 4
                                                        : int'($urandom_range(0, 26)) - 3);
      cmd.rect_height = 16'(($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 90)) - 4
                                                        : int'($urandom_range(0, 20)) - 3);
    end
    return cmd;
  endfunction

  task automatic issue(input pfre_in_t cmd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall);
    board.note_command(cmd);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue(make_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 0, 0));
    issue(make_cmd(OP_FILL_SCREEN, 0, 0, 0, 0, 1'b1, 0, 0));
    issue(make_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 127, 7));
    issue(make_cmd(OP_FILL_SCREEN, 0, 0, 0, 0, 1'b0, 0, 0));
    issue(make_cmd(OP_FILL_RECT, -3, -5, 10, 12, 1'b1, 0, 0));
    issue(make_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 0, 0));
    issue(make_cmd(OP_OUTLINE, 10, 3, 20, 30, 1'b1, 0, 0));
    issue(make_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 10, 1));
    issue(make_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 29, 4));
    issue(make_cmd(OP_OUTLINE, 120, 60, 20, 20, 1'b1, 0, 0));
    issue(make_cmd(OP_OUTLINE, -5, -5, 200, 100, 1'b1, 0, 0));
    issue(make_cmd(OP_INVERT, 0, 0, SCREEN_WIDTH, SCREEN_HEIGHT, 1'b0, 0, 0));
    issue(make_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 64, 4));
    issue(make_cmd(OP_INVERT, 100, 50, 32767, 32767, 1'b1, 0, 0));
    issue(make_cmd(OP_FILL_RECT, 4, 4, 0, 8, 1'b1, 0, 0));
    issue(make_cmd(OP_FILL_RECT, 4, 4, 8, -32768, 1'b1, 0, 0));
    issue(make_cmd(OP_FILL_RECT, SCREEN_WIDTH, 0, 4, 4, 1'b1, 0, 0));
    issue(make_cmd(OP_FILL_RECT, 0, SCREEN_HEIGHT, 4, 4, 1'b1, 0, 0));
    issue(make_cmd(OP_FILL_RECT, -32768, -32768, 32767, 32767, 1'b1, 0, 0));
    issue(make_cmd(OP_OUTLINE, 32767, 32767, 32767, 32767, 1'b0, 127, 7));
    for (logic [3:0] op = {1'b0, OP_SPARE_FIRST}; op <= {1'b0, OP_SPARE_LAST}; op++)
      issue(make_cmd(op[2:0], -1, -1, 32767, 32767, 1'b1, 127, 7));
    issue(make_cmd(OP_OUTLINE, 5, 5, 1, 1, 1'b0, 0, 0));
    issue(make_cmd(OP_FILL_RECT, -1, -1, 2, 2, 1'b1, 0, 0));
    issue(make_cmd(OP_READ, 0, 0, 0, 0, 1'b1, 127, 7));

    repeat (RANDOM_COMMANDS) issue(random_cmd());
    in_valid <= 1'b0;

    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("checked %0d results over %0d rectangle, %0d read, %0d screen fill commands",
             board.checked, board.rect_cmds, board.read_cmds, board.screen_fills);
    $display("%0d unused operation codes sent, %0d mismatches", board.spare_cmds,
             board.mismatches);
    if (board.mismatches == 0 && board.awaited_results.size() == 0) begin
      $display("page_framebuffer_rect_engine_core test passed");
    end else begin
      $display("page_framebuffer_rect_engine_core test failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("page_framebuffer_rect_engine_core test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/pfre_pkg.sv
rtl/pfre_ram.sv
rtl/pfre_clip.sv
rtl/pfre_mask.sv
rtl/page_framebuffer_rect_engine_core.sv
tb/testbench.sv
